FILE: rtl/alu16_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ALU16 package
// Opcodes, widths and the classified-item structure shared by the ALU files.
// ----------------------------------------------------------------------------
package alu16_pkg;

   localparam int unsigned WordWidth  = 16;
   localparam int unsigned OpWidth    = 5;
   localparam int unsigned QueueDepth = 2;

   typedef logic [WordWidth-1:0] word_type;

   typedef enum logic [OpWidth-1:0] {
      OP_SET = 5'd0,  OP_ADD = 5'd1,  OP_SUB = 5'd2,  OP_MUL = 5'd3,
      OP_MLI = 5'd4,  OP_DIV = 5'd5,  OP_DVI = 5'd6,  OP_MOD = 5'd7,
      OP_MDI = 5'd8,  OP_AND = 5'd9,  OP_BOR = 5'd10, OP_XOR = 5'd11,
      OP_SHR = 5'd12, OP_ASR = 5'd13, OP_SHL = 5'd14, OP_IFB = 5'd15,
      OP_IFC = 5'd16, OP_IFE = 5'd17, OP_IFN = 5'd18, OP_IFG = 5'd19,
      OP_IFA = 5'd20, OP_IFL = 5'd21, OP_IFU = 5'd22, OP_ADX = 5'd23,
      OP_SBX = 5'd24
   } op_type;

   // Execution class chosen by the front end
   typedef enum logic [2:0] {
      CLS_SIMPLE, CLS_MUL, CLS_DIV, CLS_SHIFT, CLS_TEST, CLS_NOP
   } cls_type;

   // One decoded item as it crosses the queue
   typedef struct packed {
      logic [OpWidth-1:0] op;
      cls_type            cls;
      logic               sgn;     // signed variant (mli, dvi, mdi, asr)
      logic               a_zero;
      word_type           b;
      word_type           a;
      word_type           ex;
   } item_type;

   // Result as produced by the back end
   typedef struct packed {
      word_type new_b;
      word_type ex_out;
      logic     ex_written;
      logic     condition;
   } result_type;

endpackage

FILE: rtl/alu16_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ALU16 front end
// Accepts requests, classifies the opcode and registers the decoded item.
// ----------------------------------------------------------------------------
module alu16_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [4:0]            req_type,
   input  alu16_pkg::word_type   req_operand_b,
   input  alu16_pkg::word_type   req_operand_a,
   input  alu16_pkg::word_type   req_ex_in,
   output logic                  dec_valid,
   input  logic                  dec_ready,
   output alu16_pkg::item_type   dec_item
);
   import alu16_pkg::*;

   logic     valid_ff, valid_in;
   item_type item_ff, item_in;
   cls_type  cls;
   logic     sgn;

   // Classify the opcode
   always_comb begin
      sgn = 1'b0;
      unique case (req_type) inside
         OP_SET, OP_ADD, OP_SUB, OP_AND, OP_BOR, OP_XOR, OP_ADX, OP_SBX:
            cls = CLS_SIMPLE;
         OP_MUL: cls = CLS_MUL;
         OP_MLI: begin cls = CLS_MUL; sgn = 1'b1; end
         OP_DIV, OP_MOD: cls = CLS_DIV;
         OP_DVI, OP_MDI: begin cls = CLS_DIV; sgn = 1'b1; end
         OP_SHR, OP_SHL: cls = CLS_SHIFT;
         OP_ASR: begin cls = CLS_SHIFT; sgn = 1'b1; end
         OP_IFB, OP_IFC, OP_IFE, OP_IFN, OP_IFG, OP_IFA, OP_IFL, OP_IFU:
            cls = CLS_TEST;
         default: cls = CLS_NOP;
      endcase
   end

   assign req_ready = !valid_ff || dec_ready;

   always_comb begin
      item_in.op     = req_type;
      item_in.cls    = cls;
      item_in.sgn    = sgn;
      item_in.a_zero = (req_operand_a == '0);
      item_in.b      = req_operand_b;
      item_in.a      = req_operand_a;
      item_in.ex     = req_ex_in;
      valid_in       = req_valid || (valid_ff && !dec_ready);
   end

   // Hold or advance the decode register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (req_valid && req_ready) begin
         item_ff <= item_in;
      end
   end

   assign dec_valid = valid_ff;
   assign dec_item  = item_ff;

endmodule

FILE: rtl/alu16_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ALU16 queue
// Short FIFO between front and back end so each side stalls on its own.
// ----------------------------------------------------------------------------
module alu16_queue #(
   parameter int unsigned Depth = alu16_pkg::QueueDepth
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  alu16_pkg::item_type in_item,
   output logic                out_valid,
   input  logic                out_ready,
   output alu16_pkg::item_type out_item
);
   import alu16_pkg::*;

   localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int unsigned CntW = $clog2(Depth + 1);

   item_type            mem_ff [Depth];
   logic [PtrW-1:0]     wr_ff, wr_in, rd_ff, rd_in;
   logic [CntW-1:0]     cnt_ff, cnt_in;
   logic                push, pop;

   assign in_ready  = (cnt_ff != CntW'(Depth));
   assign out_valid = (cnt_ff != '0);
   assign out_item  = mem_ff[rd_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   // Advance pointers with wrap
   always_comb begin
      wr_in  = (wr_ff == PtrW'(Depth - 1)) ? '0 : wr_ff + 1'b1;
      rd_in  = (rd_ff == PtrW'(Depth - 1)) ? '0 : rd_ff + 1'b1;
      cnt_in = cnt_ff + CntW'(push) - CntW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
         if (push) wr_ff <= wr_in;
         if (pop)  rd_ff <= rd_in;
      end
      if (push) mem_ff[wr_ff] <= in_item;
   end

endmodule

FILE: rtl/alu16_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ALU16 divider
// Pipelined restoring divider, one quotient bit per stage, on magnitudes.
// Produces a 32-bit quotient of {|b|,16'b0}/|a| and the remainder of |b|/|a|.
// ----------------------------------------------------------------------------
module alu16_div (
   input  logic                clock,
   input  logic                advance,
   input  alu16_pkg::word_type in_num,
   input  alu16_pkg::word_type in_den,
   output alu16_pkg::word_type out_quo_hi,
   output alu16_pkg::word_type out_quo_lo,
   output alu16_pkg::word_type out_rem
);
   import alu16_pkg::*;

   localparam int unsigned Steps = 2 * WordWidth;

   // Per-stage state: partial remainder, shifting dividend/quotient, divisor
   logic [WordWidth:0]     rem_ff  [Steps];
   logic [2*WordWidth-1:0] dq_ff   [Steps];
   word_type               den_ff  [Steps];
   word_type               mrem_ff [Steps];

   // Stage inputs and next values
   logic [WordWidth:0]     rem_cur  [Steps];
   logic [2*WordWidth-1:0] dq_cur   [Steps];
   word_type               den_cur  [Steps];
   word_type               mrem_cur [Steps];
   logic [WordWidth:0]     rem_in   [Steps];
   logic [2*WordWidth-1:0] dq_in    [Steps];
   word_type               mrem_in  [Steps];
   logic [WordWidth+1:0]   trial;

   // One shift-and-subtract step per stage
   always_comb begin
      rem_cur[0]  = '0;
      dq_cur[0]   = {in_num, {WordWidth{1'b0}}};
      den_cur[0]  = in_den;
      mrem_cur[0] = '0;
      for (int s = 1; s < Steps; s++) begin
         rem_cur[s]  = rem_ff[s-1];
         dq_cur[s]   = dq_ff[s-1];
         den_cur[s]  = den_ff[s-1];
         mrem_cur[s] = mrem_ff[s-1];
      end
      trial = '0;
      for (int s = 0; s < Steps; s++) begin
         trial = {rem_cur[s], dq_cur[s][2*WordWidth-1]} - {2'b00, den_cur[s]};
         if (!trial[WordWidth+1]) begin
            rem_in[s] = trial[WordWidth:0];
            dq_in[s]  = {dq_cur[s][2*WordWidth-2:0], 1'b1};
         end else begin
            rem_in[s] = {rem_cur[s][WordWidth-1:0], dq_cur[s][2*WordWidth-1]};
            dq_in[s]  = {dq_cur[s][2*WordWidth-2:0], 1'b0};
         end
         // Remainder of the integer part is ready after the first half
         mrem_in[s] = (s == WordWidth - 1) ? rem_in[s][WordWidth-1:0] : mrem_cur[s];
      end
   end

   // Advance every stage together
   always_ff @(posedge clock) begin
      if (advance) begin
         for (int s = 0; s < Steps; s++) begin
            rem_ff[s]  <= rem_in[s];
            dq_ff[s]   <= dq_in[s];
            den_ff[s]  <= den_cur[s];
            mrem_ff[s] <= mrem_in[s];
         end
      end
   end

   assign out_quo_hi = dq_ff[Steps-1][2*WordWidth-1:WordWidth];
   assign out_quo_lo = dq_ff[Steps-1][WordWidth-1:0];
   assign out_rem    = mrem_ff[Steps-1];

endmodule

FILE: rtl/alu16_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ALU16 back end
// Fixed-length execution pipeline, one carrier stage per divider stage.
// Every class rides the same pipe so results leave in order.
// ----------------------------------------------------------------------------
module alu16_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  alu16_pkg::item_type   in_item,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output alu16_pkg::result_type rsp_data
);
   import alu16_pkg::*;

   localparam int unsigned Steps = 2 * WordWidth;
   localparam int unsigned Depth = Steps;

   // Pipe advances when its last stage is empty or being drained
   logic advance;
   logic [Depth-1:0] vld_ff;
   item_type         itm_ff [Depth];
   result_type       pre_ff [Depth];   // result of non-divide classes
   logic             last_bneg, last_aneg;

   assign advance  = !vld_ff[Depth-1] || rsp_ready;
   assign in_ready = advance;

   // Non-divide result, computed at entry
   result_type pre;
   logic [2*WordWidth-1:0] prod;
   logic signed [2*WordWidth-1:0] sprod;
   logic [WordWidth:0] sum;
   logic [WordWidth+1:0] sbx;
   logic [2*WordWidth-1:0] wide;
   logic [5:0] sh;
   word_type b, a, ex;
   always_comb begin
      b = in_item.b; a = in_item.a; ex = in_item.ex;
      sh   = (a > 16'd32) ? 6'd32 : a[5:0];
      prod = b * a;
      sprod = $signed(b) * $signed(a);
      sum  = '0; sbx = '0; wide = '0;
      pre.new_b = b; pre.ex_out = ex; pre.ex_written = 1'b0; pre.condition = 1'b0;
      case (in_item.op)
         OP_SET: pre.new_b = a;
         OP_ADD: begin
            sum = {1'b0, b} + {1'b0, a};
            pre.new_b = sum[WordWidth-1:0];
            pre.ex_out = {15'd0, sum[WordWidth]}; pre.ex_written = 1'b1;
         end
         OP_SUB: begin
            pre.new_b = b - a;
            pre.ex_out = (a > b) ? 16'hFFFF : 16'h0000; pre.ex_written = 1'b1;
         end
         OP_MUL: begin
            pre.new_b = prod[15:0]; pre.ex_out = prod[31:16]; pre.ex_written = 1'b1;
         end
         OP_MLI: begin
            pre.new_b = sprod[15:0]; pre.ex_out = sprod[31:16]; pre.ex_written = 1'b1;
         end
         OP_AND: pre.new_b = b & a;
         OP_BOR: pre.new_b = b | a;
         OP_XOR: pre.new_b = b ^ a;
         OP_SHR: begin
            wide = {b, 16'h0000} >> sh;
            pre.new_b = wide[31:16]; pre.ex_out = wide[15:0]; pre.ex_written = 1'b1;
         end
         OP_ASR: begin
            wide = $unsigned($signed({b, 16'h0000}) >>> sh);
            pre.new_b = wide[31:16]; pre.ex_out = wide[15:0]; pre.ex_written = 1'b1;
         end
         OP_SHL: begin
            wide = {16'h0000, b} << sh;
            pre.new_b = wide[15:0]; pre.ex_out = wide[31:16]; pre.ex_written = 1'b1;
         end
         OP_IFB: pre.condition = (b & a) != '0;
         OP_IFC: pre.condition = (b & a) == '0;
         OP_IFE: pre.condition = b == a;
         OP_IFN: pre.condition = b != a;
         OP_IFG: pre.condition = b > a;
         OP_IFA: pre.condition = $signed(b) > $signed(a);
         OP_IFL: pre.condition = b < a;
         OP_IFU: pre.condition = $signed(b) < $signed(a);
         OP_ADX: begin
            sum = '0;
            sbx = {2'b00, b} + {2'b00, a} + {2'b00, ex};
            pre.new_b = sbx[15:0];
            pre.ex_out = (sbx > 18'h0FFFF) ? 16'h0001 : 16'h0000; pre.ex_written = 1'b1;
         end
         OP_SBX: begin
            sbx = {2'b00, b} - {2'b00, a} + {2'b00, ex};
            pre.new_b = sbx[15:0];
            if (sbx[17]) pre.ex_out = 16'hFFFF;
            else pre.ex_out = sbx[16] ? 16'h0001 : 16'h0000;
            pre.ex_written = 1'b1;
         end
         OP_DIV, OP_DVI: pre.ex_written = 1'b1;
         default: ;
      endcase
   end

   // Magnitudes into the divider
   logic bneg, aneg;
   word_type bmag, amag;
   always_comb begin
      bneg = in_item.sgn && in_item.b[WordWidth-1];
      aneg = in_item.sgn && in_item.a[WordWidth-1];
      bmag = bneg ? -in_item.b : in_item.b;
      amag = aneg ? -in_item.a : in_item.a;
   end

   word_type quo_hi, quo_lo, rem;
   alu16_div u_div (
      .clock     (clock),
      .advance   (advance),
      .in_num    (bmag),
      .in_den    (amag),
      .out_quo_hi(quo_hi),
      .out_quo_lo(quo_lo),
      .out_rem   (rem)
   );

   // Sign flags ride alongside in the item (sgn, b, a kept)
   always_comb begin
      last_bneg = itm_ff[Depth-1].sgn && itm_ff[Depth-1].b[WordWidth-1];
      last_aneg = itm_ff[Depth-1].sgn && itm_ff[Depth-1].a[WordWidth-1];
   end

   // Advance the carrier pipe
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= {vld_ff[Depth-2:0], in_valid};
      end
      if (advance) begin
         itm_ff[0] <= in_item;
         pre_ff[0] <= pre;
         for (int i = 1; i < Depth; i++) begin
            itm_ff[i] <= itm_ff[i-1];
            pre_ff[i] <= pre_ff[i-1];
         end
      end
   end

   // Resolve signs and the divide-by-zero case at the exit; the integer
   // quotient and the fraction are negated separately so both truncate to zero
   item_type last;
   logic qneg;
   word_type r;
   always_comb begin
      last = itm_ff[Depth-1];
      rsp_data = pre_ff[Depth-1];
      qneg = last_bneg ^ last_aneg;
      r  = last_bneg ? -rem : rem;
      if (last.cls == CLS_DIV) begin
         if (last.a_zero) begin
            rsp_data.new_b = '0;
            if (last.op == OP_DIV || last.op == OP_DVI) rsp_data.ex_out = '0;
         end else if (last.op == OP_DIV || last.op == OP_DVI) begin
            rsp_data.new_b  = qneg ? -quo_hi : quo_hi;
            rsp_data.ex_out = qneg ? -quo_lo : quo_lo;
         end else begin
            rsp_data.new_b = r;
         end
      end
   end

   assign rsp_valid = vld_ff[Depth-1];

endmodule

FILE: rtl/sixteen_bit_alu_with_overflow_word.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sixteen-bit ALU with overflow word
// Top level: front end, decoupling queue and back-end execution pipeline.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel req_*: opcode, operands b and a, current overflow word.
//   Response channel rsp_*: new b, new overflow word, its write flag and the
//   outcome of the skip tests. One response per request, in order.
//   A request passes one decode register, the queue and a 32-stage back end
//   set by the pipelined divider (one quotient bit per stage, 32 stages).
//   Throughput is one transfer per cycle while the receiver keeps rsp_ready
//   high; all operations share the pipe.
//   Reset clears every valid flag and the queue; payload is not cleared.
//   A stalled receiver freezes the back end; the queue then the front end
//   fill and req_ready drops after that. No transfer is lost.
// ----------------------------------------------------------------------------
module sixteen_bit_alu_with_overflow_word #(
   parameter int unsigned QueueDepth = alu16_pkg::QueueDepth
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [4:0]          req_type,
   input  alu16_pkg::word_type req_operand_b,
   input  alu16_pkg::word_type req_operand_a,
   input  alu16_pkg::word_type req_ex_in,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output alu16_pkg::word_type rsp_new_b,
   output alu16_pkg::word_type rsp_ex_out,
   output logic                rsp_ex_written,
   output logic                rsp_condition
);
   import alu16_pkg::*;

   logic       dec_valid, dec_ready, exe_valid, exe_ready;
   item_type   dec_item, exe_item;
   result_type res;

   alu16_front u_front (
      .clock, .reset, .req_valid, .req_ready, .req_type,
      .req_operand_b, .req_operand_a, .req_ex_in,
      .dec_valid, .dec_ready, .dec_item
   );

   alu16_queue #(.Depth(QueueDepth)) u_queue (
      .clock, .reset,
      .in_valid (dec_valid), .in_ready (dec_ready), .in_item (dec_item),
      .out_valid(exe_valid), .out_ready(exe_ready), .out_item(exe_item)
   );

   alu16_back u_back (
      .clock, .reset,
      .in_valid (exe_valid), .in_ready (exe_ready), .in_item (exe_item),
      .rsp_valid, .rsp_ready, .rsp_data (res)
   );

   assign rsp_new_b      = res.new_b;
   assign rsp_ex_out     = res.ex_out;
   assign rsp_ex_written = res.ex_written;
   assign rsp_condition  = res.condition;

   // A stalled response holds its value
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_new_b) && $stable(rsp_ex_out))
      else $error("stalled response changed");

   // Skip tests never write the overflow word
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_condition |-> !rsp_ex_written)
      else $error("condition with overflow write");

   // Queue output stays valid while the back end stalls it
   assert property (@(posedge clock) disable iff (reset)
      exe_valid && !exe_ready |=> exe_valid)
      else $error("queue lost an item");

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sixteen-bit ALU with overflow word testbench
// Drives opcodes and operands through the request channel, predicts each
// response in a scoreboard and compares it field by field, in order, under
// several idling mixes and one long receiver hold-off.
// ----------------------------------------------------------------------------

module tb_top;
   import alu16_pkg::*;

   // Expected response fields
   typedef struct {
      logic [15:0] new_b;
      logic [15:0] ex_out;
      logic        ex_written;
      logic        condition;
   } alu_result_type;

   // Scoreboard: predicts responses and holds them in order
   class alu_scoreboard;
      alu_result_type pending[$];
      int             mismatches;
      int             checked;

      // Work out the response for one operation
      function alu_result_type compute(logic [4:0] op, logic [15:0] b, logic [15:0] a,
                                       logic [15:0] ex);
         alu_result_type r;
         logic [63:0]   wide;
         logic [31:0]   prod;
         longint        sb, sa, q, d;
         int unsigned   cnt;
         sb = longint'($signed(b));
         sa = longint'($signed(a));
         cnt = (a > 32) ? 32 : a;
         r.new_b = b;
         r.ex_out = ex;
         r.ex_written = 1'b0;
         r.condition = 1'b0;
         case (op)
            OP_SET: r.new_b = a;
            OP_ADD, OP_ADX: begin
               wide = 64'(b) + 64'(a) + ((op == OP_ADX) ? 64'(ex) : 64'd0);
               r.new_b = wide[15:0];
               r.ex_out = (wide > 64'hFFFF) ? 16'd1 : 16'd0;
               r.ex_written = 1'b1;
            end
            OP_SUB: begin
               r.new_b = b - a;
               r.ex_out = (a > b) ? 16'hFFFF : 16'd0;
               r.ex_written = 1'b1;
            end
            OP_MUL: begin
               prod = 32'(b) * 32'(a);
               {r.ex_out, r.new_b} = prod;
               r.ex_written = 1'b1;
            end
            OP_MLI: begin
               prod = 32'(sb * sa);
               {r.ex_out, r.new_b} = prod;
               r.ex_written = 1'b1;
            end
            OP_DIV: begin
               r.ex_written = 1'b1;
               if (a == 0) begin
                  r.new_b = 0;
                  r.ex_out = 0;
               end else begin
                  wide = (64'(b) << 16) / 64'(a);
                  r.ex_out = wide[15:0];
                  r.new_b = b / a;
               end
            end
            OP_DVI: begin
               r.ex_written = 1'b1;
               if (a == 0) begin
                  r.new_b = 0;
                  r.ex_out = 0;
               end else begin
                  q = (sb * 65536) / sa;
                  r.ex_out = q[15:0];
                  q = sb / sa;
                  r.new_b = q[15:0];
               end
            end
            OP_MOD: r.new_b = (a == 0) ? 16'd0 : b % a;
            OP_MDI: begin
               q = (a == 0) ? 0 : sb % sa;
               r.new_b = q[15:0];
            end
            OP_AND: r.new_b = b & a;
            OP_BOR: r.new_b = b | a;
            OP_XOR: r.new_b = b ^ a;
            OP_SHR: begin
               wide = (64'(b) << 16) >> cnt;
               {r.new_b, r.ex_out} = wide[31:0];
               r.ex_written = 1'b1;
            end
            OP_ASR: begin
               wide = 64'($signed(sb * 65536) >>> cnt);
               {r.new_b, r.ex_out} = wide[31:0];
               r.ex_written = 1'b1;
            end
            OP_SHL: begin
               wide = 64'(b) << cnt;
               {r.ex_out, r.new_b} = wide[31:0];
               r.ex_written = 1'b1;
            end
            OP_IFB: r.condition = (b & a) != 0;
            OP_IFC: r.condition = (b & a) == 0;
            OP_IFE: r.condition = b == a;
            OP_IFN: r.condition = b != a;
            OP_IFG: r.condition = b > a;
            OP_IFA: r.condition = sb > sa;
            OP_IFL: r.condition = b < a;
            OP_IFU: r.condition = sb < sa;
            OP_SBX: begin
               d = longint'(b) - longint'(a) + longint'(ex);
               r.new_b = d[15:0];
               r.ex_out = (d < 0) ? 16'hFFFF : ((d > 65535) ? 16'd1 : 16'd0);
               r.ex_written = 1'b1;
            end
            default: ;
         endcase
         return r;
      endfunction

      // Note an accepted request
      function void note_request(logic [4:0] op, logic [15:0] b, logic [15:0] a,
                                 logic [15:0] ex);
         pending.push_back(compute(op, b, a, ex));
      endfunction

      // Compare one accepted response against the oldest prediction
      function void check_response(logic [15:0] nb, logic [15:0] nex, logic wr,
                                   logic cond);
         alu_result_type e;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("ERROR: unexpected response new_b=%h ex=%h", nb, nex);
            return;
         end
         e = pending.pop_front();
         checked++;
         if (nb !== e.new_b || nex !== e.ex_out || wr !== e.ex_written ||
             cond !== e.condition) begin
            mismatches++;
            if (mismatches <= 10)
               $display("ERROR: exp b=%h ex=%h wr=%b c=%b, got b=%h ex=%h wr=%b c=%b",
                        e.new_b, e.ex_out, e.ex_written, e.condition,
                        nb, nex, wr, cond);
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [4:0]  req_type;
   word_type    req_operand_b;
   word_type    req_operand_a;
   word_type    req_ex_in;
   logic        rsp_valid;
   logic        rsp_ready;
   word_type    rsp_new_b;
   word_type    rsp_ex_out;
   logic        rsp_ex_written;
   logic        rsp_condition;

   alu_scoreboard sb_h = new();
   int          send_idle_pct;
   int          recv_stall_pct;
   bit          hold_off;
   int          hold_cycles;
   longint      cycle_count = 0;
   int          sent;

   sixteen_bit_alu_with_overflow_word dut (.*);

   // Clock
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Cycle limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 400000) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // Check each response transfer
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb_h.check_response(rsp_new_b, rsp_ex_out, rsp_ex_written, rsp_condition);
   end

   // Receiver: random stalls, or a long counted hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         hold_cycles <= 0;
      end else if (hold_off && hold_cycles < 300) begin
         hold_cycles <= hold_cycles + 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Offer one request and hold it until transferred
   task automatic send_op(logic [4:0] op, logic [15:0] b, logic [15:0] a,
                          logic [15:0] ex);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_type <= op;
      req_operand_b <= b;
      req_operand_a <= a;
      req_ex_in <= ex;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb_h.note_request(op, b, a, ex);
      sent++;
   endtask

   // Random operand biased toward edge values
   function automatic logic [15:0] pick_word();
      case ($urandom_range(7))
         0: return 16'h0000;
         1: return 16'hFFFF;
         2: return 16'h8000;
         3: return 16'h7FFF;
         4: return 16'($urandom_range(40));
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic send_random(int n);
      logic [4:0] op;
      for (int i = 0; i < n; i++) begin
         op = ($urandom_range(19) == 0) ? 5'($urandom) : 5'($urandom_range(24));
         send_op(op, pick_word(), pick_word(), pick_word());
      end
   endtask

   // Wait until every expected response has come
   task automatic drain();
      int guard;
      guard = 0;
      req_valid <= 1'b0;
      while (sb_h.pending.size() != 0 && guard < 20000) begin
         @(posedge clock);
         guard++;
      end
   endtask

   initial begin
      logic [15:0] vals[4];
      sent = 0;
      hold_off = 0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_type = '0;
      req_operand_b = '0;
      req_operand_a = '0;
      req_ex_in = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed: every opcode with edge operands, then the special cases
      vals = '{16'h0000, 16'hFFFF, 16'h8000, 16'h7FFF};
      for (int op = 0; op < 32; op++)
         send_op(5'(op), vals[op % 4], vals[(op / 4) % 4], 16'hFFFF);
      send_op(OP_DVI, 16'h8000, 16'hFFFF, 16'h0);
      send_op(OP_DIV, 16'h1234, 16'h0, 16'h5555);
      send_op(OP_MDI, 16'h8001, 16'h0, 16'h5555);
      send_op(OP_MDI, 16'h8001, 16'h0007, 16'h0);
      send_op(OP_ASR, 16'h8001, 16'd20, 16'h0);
      send_op(OP_SHL, 16'hABCD, 16'd31, 16'h0);
      send_op(OP_SHR, 16'hABCD, 16'd32, 16'h0);
      send_op(OP_SBX, 16'h0000, 16'hFFFF, 16'hFFFF);
      send_op(OP_ADX, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      drain();

      // Idling mixes
      send_random(300);
      send_idle_pct = 70;
      send_random(250);
      send_idle_pct = 0;
      recv_stall_pct = 70;
      send_random(250);
      send_idle_pct = 15;
      recv_stall_pct = 15;
      send_random(200);

      // Pause the sender until all responses are in
      drain();

      // Long receiver hold-off while the sender keeps offering
      send_idle_pct = 0;
      recv_stall_pct = 0;
      hold_off = 1;
      send_random(110);
      drain();
      hold_off = 0;
      repeat (40) @(posedge clock);

      $display("Sent %0d requests over all opcodes, %0d responses checked.",
               sent, sb_h.checked);
      $display("Covered idle mixes, a long receiver hold-off and edge operands.");
      if (sb_h.mismatches == 0 && sb_h.pending.size() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

FILE: filelist.f
rtl/alu16_pkg.sv
rtl/alu16_front.sv
rtl/alu16_queue.sv
rtl/alu16_div.sv
rtl/alu16_back.sv
rtl/sixteen_bit_alu_with_overflow_word.sv
tb/tb_top.sv
